// ===== src/hcbe_pkg.sv =====
`timescale 1ns / 1ps

package hcbe_pkg;

    localparam int MAX_KEY_SIZE = 4;
    localparam int LETTER_W     = 5;
    localparam int ROW_W        = 20;
    localparam int SIZE_W       = 3;
    localparam int CFG_ADDR_W   = 3;

    localparam logic [4:0] MODULUS    = 5'd26;
    localparam logic [4:0] PAD_LETTER = 5'd23;
    localparam logic [4:0] BAD_DET    = 5'd13;

    localparam logic [CFG_ADDR_W-1:0] REG_KEY_SIZE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW0 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW1 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW2 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_ROW3 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE     = 3'd5;

    localparam int N_PERM = 24;

    // All permutations of 0..3 in lexicographic order, digit k at bits 2k+1:2k.
    // Parity of entry p is p[0] ^ p[1].
    localparam logic [7:0] PERM [N_PERM] = '{
        8'd228, 8'd180, 8'd216, 8'd120, 8'd156, 8'd108,
        8'd225, 8'd177, 8'd201, 8'd57,  8'd141, 8'd45,
        8'd210, 8'd114, 8'd198, 8'd54,  8'd78,  8'd30,
        8'd147, 8'd99,  8'd135, 8'd39,  8'd75,  8'd27
    };

    function automatic logic [4:0] red26(input logic [4:0] v);
        red26 = (v >= MODULUS) ? v - MODULUS : v;
    endfunction

    // x mod 26 for x < 1024: reciprocal estimate, at most one correction
    function automatic logic [4:0] mod26(input logic [9:0] x);
        logic [16:0] t;
        logic [5:0]  q;
        logic [10:0] r;
        t = {7'd0, x} * 17'd78;
        q = t[16:11];
        r = {1'b0, x} - ({5'd0, q} * 11'd26);
        if (r >= 11'd26) begin
            r = r - 11'd26;
        end
        mod26 = r[4:0];
    endfunction

endpackage

// ===== src/hill_cipher_block_engine_top.sv =====
`timescale 1ns / 1ps
// Hill cipher mod 26 engine, one shared 5x5 multiply / mod-26 unit.
// A letter that completes a block of N (or ends the message) starts the N x N
// multiply-accumulate, which gives one result per row; other letters are only buffered.
// The first letter of an encrypt message first runs the determinant
// check (24 permutation terms, 4 multiplies each, through the same unit).
// One letter at a time: a new letter is taken only while the engine is idle.
// Reset (synchronous, active low) restores the register defaults and idles.
module hill_cipher_block_engine_top #(
    parameter int P_MAX_KEY_SIZE = hcbe_pkg::MAX_KEY_SIZE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hcbe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [hcbe_pkg::ROW_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [hcbe_pkg::LETTER_W-1:0]   i_letter_in,
    input  logic                            i_message_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hcbe_pkg::LETTER_W-1:0]   o_letter_out,
    output logic                            o_final_out,
    output logic                            o_status
);
    import hcbe_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DET, S_APPLY, S_MAC} t_state;

    t_state      r_state;
    logic [2:0]  r_key_size;
    logic [19:0] r_key_row [4];
    logic        r_mode;

    logic [4:0]  r_buf [4];
    logic [2:0]  r_fill;
    logic        r_started;
    logic        r_kvalid;
    logic [4:0]  r_letter;
    logic        r_end;
    logic [4:0]  r_perm;
    logic [1:0]  r_k;
    logic [4:0]  r_prod;
    logic [4:0]  r_acc;
    logic [1:0]  r_row;
    logic [1:0]  r_col;

    logic        r_ov;
    logic [4:0]  r_olet;
    logic        r_ofin;
    logic        r_ost;

    logic [2:0]  eff_n;
    logic [1:0]  sel_r, sel_c;
    logic [4:0]  kent, mul_a, mul_b, m, addend, n_acc;
    logic [5:0]  sum;
    logic        sub;
    logic [7:0]  pdig;
    logic        out_free;
    logic        beat_load;
    logic [2:0]  fill_inc;

    always_comb begin
        eff_n = r_key_size;
        if (eff_n == 3'd0) begin
            eff_n = 3'd1;
        end
        if (eff_n > 3'(P_MAX_KEY_SIZE)) begin
            eff_n = 3'(P_MAX_KEY_SIZE);
        end
    end

    assign pdig = PERM[r_perm];

    always_comb begin
        logic [19:0] row;
        logic [4:0]  f;
        if (r_state == S_DET) begin
            sel_r = r_k;
            case (r_k)
                2'd0:    sel_c = pdig[1:0];
                2'd1:    sel_c = pdig[3:2];
                2'd2:    sel_c = pdig[5:4];
                default: sel_c = pdig[7:6];
            endcase
        end else begin
            sel_r = r_row;
            sel_c = r_col;
        end
        row = r_key_row[sel_r];
        case (sel_c)
            2'd0:    f = row[4:0];
            2'd1:    f = row[9:5];
            2'd2:    f = row[14:10];
            default: f = row[19:15];
        endcase
        // outside the N x N corner the matrix reads as identity
        if ({1'b0, sel_r} < eff_n && {1'b0, sel_c} < eff_n) begin
            kent = red26(f);
        end else begin
            kent = (sel_r == sel_c) ? 5'd1 : 5'd0;
        end

        if (r_state == S_DET) begin
            mul_a = (r_k == 2'd0) ? 5'd1 : r_prod;
            mul_b = kent;
            sub   = r_perm[0] ^ r_perm[1];
        end else begin
            mul_a = kent;
            mul_b = r_buf[r_col];
            sub   = 1'b0;
        end
        m      = mod26({5'd0, mul_a} * {5'd0, mul_b});
        addend = (sub && m != 5'd0) ? MODULUS - m : m;
        sum    = {1'b0, r_acc} + {1'b0, addend};
        n_acc  = (sum >= 6'd26) ? 5'(sum - 6'd26) : sum[4:0];
    end

    assign out_free   = !r_ov || i_out_ready;
    // a result beat is loaded into the output register this cycle
    assign beat_load  = out_free &&
                        ((r_state == S_APPLY && !r_kvalid && r_end) ||
                         (r_state == S_MAC && {1'b0, r_col} == eff_n - 3'd1));
    assign fill_inc   = r_fill + 3'd1;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_letter_out = r_olet;
    assign o_final_out  = r_ofin;
    assign o_status     = r_ost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_key_size <= 3'd2;
            for (int i = 0; i < 4; i++) begin
                r_key_row[i] <= '0;
                r_buf[i]     <= '0;
            end
            r_mode    <= 1'b0;
            r_fill    <= '0;
            r_started <= 1'b0;
            r_kvalid  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && !beat_load) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_KEY_SIZE: r_key_size   <= i_cfg_wdata[2:0];
                    REG_KEY_ROW0: r_key_row[0] <= i_cfg_wdata;
                    REG_KEY_ROW1: r_key_row[1] <= i_cfg_wdata;
                    REG_KEY_ROW2: r_key_row[2] <= i_cfg_wdata;
                    REG_KEY_ROW3: r_key_row[3] <= i_cfg_wdata;
                    REG_MODE:     r_mode       <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_letter <= red26(i_letter_in);
                        r_end    <= i_message_end;
                        r_state  <= S_APPLY;
                        if (!r_started) begin
                            r_started <= 1'b1;
                            r_fill    <= '0;
                            if (r_mode) begin
                                r_kvalid <= 1'b1;
                            end else begin
                                r_perm  <= '0;
                                r_k     <= '0;
                                r_acc   <= '0;
                                r_state <= S_DET;
                            end
                        end
                    end
                end

                S_DET: begin
                    r_prod <= m;
                    r_k    <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_acc  <= n_acc;
                        r_perm <= r_perm + 5'd1;
                        if (r_perm == 5'(N_PERM - 1)) begin
                            r_kvalid <= n_acc[0] && (n_acc != BAD_DET);
                            r_state  <= S_APPLY;
                        end
                    end
                end

                S_APPLY: begin
                    if (!r_kvalid) begin
                        if (!r_end) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_ov      <= 1'b1;
                            r_olet    <= '0;
                            r_ofin    <= 1'b1;
                            r_ost     <= 1'b1;
                            r_started <= 1'b0;
                            r_fill    <= '0;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        r_buf[r_fill[1:0]] <= r_letter;
                        r_row <= '0;
                        r_col <= '0;
                        r_acc <= '0;
                        if (fill_inc >= eff_n || r_end) begin
                            // short final block: pad the tail with X
                            if (fill_inc < eff_n) begin
                                for (int k = 0; k < 4; k++) begin
                                    if (3'(k) >= fill_inc && 3'(k) < eff_n) begin
                                        r_buf[k] <= PAD_LETTER;
                                    end
                                end
                            end
                            r_state <= S_MAC;
                        end else begin
                            r_fill  <= fill_inc;
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_MAC: begin
                    if ({1'b0, r_col} == eff_n - 3'd1) begin
                        if (out_free) begin
                            r_ov   <= 1'b1;
                            r_olet <= n_acc;
                            r_ofin <= r_end && ({1'b0, r_row} == eff_n - 3'd1);
                            r_ost  <= 1'b0;
                            r_acc  <= '0;
                            r_col  <= '0;
                            r_row  <= r_row + 2'd1;
                            if ({1'b0, r_row} == eff_n - 3'd1) begin
                                r_fill  <= '0;
                                r_state <= S_IDLE;
                                if (r_end) begin
                                    r_started <= 1'b0;
                                end
                            end
                        end
                    end else begin
                        r_acc <= n_acc;
                        r_col <= r_col + 2'd1;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
